/* rtl/socc_pkg.sv */
// Shared types, codes and the ones'-complement fold for the segment checksum unit.
`timescale 1ns / 1ps
`default_nettype none

package socc_pkg;

    // Request kinds carried in s_tuser.
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    // Input payload layout in s_tdata, lowest bit first.
    localparam int unsigned SEG_TYPE_W  = 8;
    localparam int unsigned SEQ_NUM_W   = 32;
    localparam int unsigned ACK_NUM_W   = 32;
    localparam int unsigned DATA_LEN_W  = 16;
    localparam int unsigned GIVEN_CSUM_W = 16;
    localparam int unsigned DATA_BYTE_W = 8;

    localparam int unsigned SEG_TYPE_LSB   = 0;
    localparam int unsigned SEQ_NUM_LSB    = SEG_TYPE_LSB + SEG_TYPE_W;
    localparam int unsigned ACK_NUM_LSB    = SEQ_NUM_LSB + SEQ_NUM_W;
    localparam int unsigned DATA_LEN_LSB   = ACK_NUM_LSB + ACK_NUM_W;
    localparam int unsigned GIVEN_CSUM_LSB = DATA_LEN_LSB + DATA_LEN_W;
    localparam int unsigned DATA_BYTE_LSB  = GIVEN_CSUM_LSB + GIVEN_CSUM_W;
    localparam int unsigned S_TDATA_W      = DATA_BYTE_LSB + DATA_BYTE_W;

    localparam int unsigned M_TDATA_W = 16;

    // Command queue between the front and back parts.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        CMD_HDR  = 1'b0,
        CMD_WORD = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;
        logic [15:0] value;
        logic [15:0] expected;
    } cmd_t;

    // Folds a sum of up to eight 16-bit words back into 16 bits with end-around carry.
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] f1;
        f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        return f1[15:0] + {15'b0, f1[16]};
    endfunction

endpackage

`default_nettype wire

/* rtl/socc_front.sv */
// Front part: accepts requests, sums header fields, pairs payload bytes into words.
`timescale 1ns / 1ps
`default_nettype none

module socc_front import socc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    logic        in_seg_reg, in_seg_next;
    logic [15:0] left_reg, left_next;
    logic        odd_reg, odd_next;
    logic [7:0]  held_reg, held_next;

    logic                    accept;
    logic [SEG_TYPE_W-1:0]   seg_type;
    logic [SEQ_NUM_W-1:0]    seq_num;
    logic [ACK_NUM_W-1:0]    ack_num;
    logic [DATA_LEN_W-1:0]   data_len;
    logic [GIVEN_CSUM_W-1:0] given_checksum;
    logic [DATA_BYTE_W-1:0]  data_byte;
    logic [18:0]             hdr_total;
    logic                    last_byte;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign seg_type       = s_tdata[SEG_TYPE_LSB +: SEG_TYPE_W];
    assign seq_num        = s_tdata[SEQ_NUM_LSB +: SEQ_NUM_W];
    assign ack_num        = s_tdata[ACK_NUM_LSB +: ACK_NUM_W];
    assign data_len       = s_tdata[DATA_LEN_LSB +: DATA_LEN_W];
    assign given_checksum = s_tdata[GIVEN_CSUM_LSB +: GIVEN_CSUM_W];
    assign data_byte      = s_tdata[DATA_BYTE_LSB +: DATA_BYTE_W];

    assign hdr_total = {11'b0, seg_type}
                     + {3'b0, seq_num[15:0]} + {3'b0, seq_num[31:16]}
                     + {3'b0, ack_num[15:0]} + {3'b0, ack_num[31:16]}
                     + {3'b0, data_len};

    assign last_byte = (left_reg == 16'd1);

    always_comb begin
        in_seg_next = in_seg_reg;
        left_next   = left_reg;
        odd_next    = odd_reg;
        held_next   = held_reg;
        q_push      = 1'b0;
        q_cmd       = '{kind: CMD_HDR, last: 1'b0, value: 16'h0000, expected: 16'h0000};
        if (accept) begin
            if (s_tuser == REQ_HEADER) begin
                in_seg_next = (data_len != 16'd0);
                left_next   = data_len;
                odd_next    = 1'b0;
                q_push      = 1'b1;
                q_cmd       = '{kind: CMD_HDR, last: (data_len == 16'd0),
                                value: oc_fold(hdr_total), expected: given_checksum};
            end else if (in_seg_reg) begin
                left_next = left_reg - 16'd1;
                if (!odd_reg && !last_byte) begin
                    held_next = data_byte;
                    odd_next  = 1'b1;
                end else begin
                    // A lone final byte goes out as the high byte padded with zero.
                    odd_next = 1'b0;
                    q_push   = 1'b1;
                    q_cmd    = '{kind: CMD_WORD, last: last_byte,
                                 value: odd_reg ? {held_reg, data_byte} : {data_byte, 8'h00},
                                 expected: 16'h0000};
                end
                if (last_byte) begin
                    in_seg_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_seg_reg <= 1'b0;
            left_reg   <= 16'd0;
            odd_reg    <= 1'b0;
        end else begin
            in_seg_reg <= in_seg_next;
            left_reg   <= left_next;
            odd_reg    <= odd_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

/* rtl/socc_queue.sv */
// Short command queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`default_nettype none

module socc_queue import socc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

/* rtl/socc_back.sv */
// Back part: accumulates words with end-around carry and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module socc_back import socc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 head,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    logic [15:0] sum_reg, sum_next;
    logic [15:0] exp_reg, exp_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] csum_reg, csum_next;
    logic        ok_reg, ok_next;

    logic        out_free;
    logic [16:0] word_add;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = !empty && out_free;
    assign word_add = {1'b0, sum_reg} + {1'b0, head.value};

    always_comb begin
        sum_next      = sum_reg;
        exp_next      = exp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        csum_next     = csum_reg;
        ok_next       = ok_reg;
        if (pop) begin
            if (head.kind == CMD_HDR) begin
                sum_next = head.value;
                exp_next = head.expected;
            end else begin
                sum_next = oc_fold({2'b0, word_add});
            end
            if (head.last) begin
                m_tvalid_next = 1'b1;
                csum_next     = ~sum_next;
                ok_next       = (~sum_next == exp_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            sum_reg      <= 16'h0000;
            exp_reg      <= 16'h0000;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            sum_reg      <= sum_next;
            exp_reg      <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        csum_reg <= csum_next;
        ok_reg   <= ok_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = csum_reg;
    assign m_tuser  = ok_reg;

endmodule

`default_nettype wire

/* rtl/segment_ones_complement_checksum_unit.sv */
// Top level of the segment ones'-complement checksum unit.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one request per clock: a header request starts a segment and a data
// request carries one payload byte. Headers are summed in the cycle they are accepted,
// bytes are paired into 16-bit words, and a four-entry command queue feeds a single
// end-around-carry adder that retires one command per cycle while the output register
// is free. With nothing queued ahead, a segment's result passes through the queue and
// the output register after its last byte (or its header, for an empty segment) is
// accepted and sits in the output register until taken; s_tready drops only when the
// command queue fills because results are not being taken. A new header abandons an
// unfinished segment without a result, and data requests outside a segment are dropped.

module segment_ones_complement_checksum_unit import socc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // seg_type[7:0], seq_num[39:8], ack_num[71:40], data_len[87:72],
    // given_checksum[103:88], data_byte[111:104]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // checksum[15:0]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // valid_res[0]
    output logic                      m_tuser
);

    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    socc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    socc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    socc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
